/* design/png_chunk_deframer_defines.svh */
// Assertion macros shared by the deframer modules.
`ifndef PNG_CHUNK_DEFRAMER_DEFINES_SVH
`define PNG_CHUNK_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PCD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/pcd_pkg.sv */
// Shared types, codes and constants of the PNG chunk deframer.
package pcd_pkg;

    // Framing phase of the byte parser
    typedef enum logic [2:0] {
        PH_SIG,
        PH_LEN,
        PH_TYPE,
        PH_PAY,
        PH_CRC,
        PH_DONE,
        PH_REJ
    } phase_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_PARSE  = 2'd0,
        ST_CHUNK  = 2'd1,
        ST_ACCEPT = 2'd2,
        ST_REJECT = 2'd3
    } status_t;

    // Chunk kinds
    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_IDAT  = 2'd1,
        KIND_FDAT  = 2'd2,
        KIND_IEND  = 2'd3
    } kind_t;

    // Per-byte event codes from the framer to the checker
    typedef enum logic [1:0] {
        EV_PARSE,
        EV_CHUNK,
        EV_DONE,
        EV_REJ
    } evt_code_t;

    localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
    localparam logic [31:0] TYPE_FDAT = 32'h6664_4154;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

    // Event passed through the queue, one per input byte
    typedef struct packed {
        logic        restart;
        evt_code_t   code;
        logic        last;
        logic [31:0] type_word;
        logic [31:0] len;
        logic [31:0] crc;
    } evt_t;

    // Result item
    typedef struct packed {
        status_t     status;
        kind_t       kind;
        logic        run;
        logic [31:0] len;
        logic [31:0] crc;
    } res_t;

    // PNG file signature byte at a given position
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] val;
        unique case (idx)
            3'd0: val = 8'h89;
            3'd1: val = 8'h50;
            3'd2: val = 8'h4e;
            3'd3: val = 8'h47;
            3'd4: val = 8'h0d;
            3'd5: val = 8'h0a;
            3'd6: val = 8'h1a;
            3'd7: val = 8'h0a;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

/* design/png_chunk_deframer.sv */
// PNG chunk deframer top level: stream ports, framer, event queue and checker.
//
// Takes a PNG file one byte per transfer and returns exactly one result per
// byte, at a sustained rate of one byte per clock while m_axis_tready stays
// high. The framer handles a byte in the cycle it is accepted; its parse state
// (phase, field counter, length, payload countdown) is updated on each accepted
// byte. A byte's result is offered on the master side from the checker's output
// register once it has passed the event queue. While the master side is stalled, the
// event queue of QUEUE_DEPTH entries plus the output register take up to
// QUEUE_DEPTH + 1 bytes before s_axis_tready drops. A byte with s_axis_tuser
// set restarts the parse; s_axis_tlast marks the end of input, which rejects
// the file unless that byte completes IEND. After accept or reject, further
// bytes answer with the same status until the next restart.
module png_chunk_deframer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    input  logic [0:0]  s_axis_tuser,   // [0] first_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] chunk_length, [63:32] chunk_crc
    output logic [4:0]  m_axis_tuser    // [1:0] status, [3:2] chunk_kind, [4] starts_run
);
    import pcd_pkg::*;

    logic evt_valid;
    logic evt_ready;
    evt_t evt;
    logic q_valid;
    logic q_ready;
    evt_t q_evt;
    res_t res;

    pcd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .data_byte  (s_axis_tdata),
        .first_byte (s_axis_tuser[0]),
        .last_byte  (s_axis_tlast),
        .evt_valid  (evt_valid),
        .evt_ready  (evt_ready),
        .evt        (evt)
    );

    pcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (evt_valid),
        .in_ready  (evt_ready),
        .in_evt    (evt),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_evt   (q_evt)
    );

    pcd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_evt     (q_evt),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    // Pack the result onto the master side
    assign m_axis_tdata = {res.crc, res.len};
    assign m_axis_tuser = {res.run, res.kind, res.status};

endmodule

/* design/pcd_front.sv */
// Byte framer: signature check, length/type/payload/CRC framing, one event per byte.
module pcd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    data_byte,
    input  logic          first_byte,
    input  logic          last_byte,
    output logic          evt_valid,
    input  logic          evt_ready,
    output pcd_pkg::evt_t evt
);
    import pcd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] type_reg, type_next;
    logic [31:0] crc_reg, crc_next;

    phase_t      cur_phase;
    logic [2:0]  cur_cnt;
    logic [31:0] cur_len;
    logic [31:0] cur_type;
    logic [31:0] cur_crc;
    logic        chunk_end;
    logic        accept;

    assign in_ready  = evt_ready;
    assign evt_valid = in_valid;
    assign accept    = in_valid && evt_ready;

    // Restart clears the parse before this byte is looked at
    always_comb
    begin
        cur_phase = first_byte ? PH_SIG : phase_reg;
        cur_cnt   = first_byte ? 3'd0   : cnt_reg;
        cur_len   = first_byte ? 32'd0  : len_reg;
        cur_type  = first_byte ? 32'd0  : type_reg;
        cur_crc   = first_byte ? 32'd0  : crc_reg;
    end

    // Advance the framing phase and build the event
    always_comb
    begin
        phase_next    = cur_phase;
        cnt_next      = cur_cnt;
        len_next      = cur_len;
        left_next     = first_byte ? 32'd0 : left_reg;
        type_next     = cur_type;
        crc_next      = cur_crc;
        chunk_end     = 1'b0;
        evt.restart   = first_byte;
        evt.code      = EV_PARSE;
        evt.last      = last_byte;
        evt.type_word = cur_type;
        evt.len       = cur_len;
        evt.crc       = '0;

        unique case (cur_phase)
            PH_SIG:
            begin
                if (data_byte != sig_byte(cur_cnt))
                begin
                    phase_next = PH_REJ;
                end
                else if (cur_cnt == 3'd7)
                begin
                    phase_next = PH_LEN;
                    cnt_next   = 3'd0;
                end
                else
                begin
                    cnt_next = cur_cnt + 3'd1;
                end
            end
            PH_LEN:
            begin
                len_next = {cur_len[23:0], data_byte};
                if (cur_cnt == 3'd3)
                begin
                    phase_next = PH_TYPE;
                    cnt_next   = 3'd0;
                end
                else
                begin
                    cnt_next = cur_cnt + 3'd1;
                end
            end
            PH_TYPE:
            begin
                type_next = {cur_type[23:0], data_byte};
                if (cur_cnt == 3'd3)
                begin
                    cnt_next   = 3'd0;
                    left_next  = cur_len;
                    phase_next = (cur_len == 32'd0) ? PH_CRC : PH_PAY;
                end
                else
                begin
                    cnt_next = cur_cnt + 3'd1;
                end
            end
            PH_PAY:
            begin
                left_next = left_reg - 32'd1;
                if (left_reg == 32'd1)
                begin
                    phase_next = PH_CRC;
                end
            end
            PH_CRC:
            begin
                crc_next = {cur_crc[23:0], data_byte};
                if (cur_cnt != 3'd3)
                begin
                    cnt_next = cur_cnt + 3'd1;
                end
                else
                begin
                    // Close the chunk; the checker decides its status
                    chunk_end = 1'b1;
                    cnt_next  = 3'd0;
                    evt.code  = EV_CHUNK;
                    evt.crc   = crc_next;
                    len_next  = 32'd0;
                    if (cur_type == TYPE_IEND)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (last_byte)
                    begin
                        phase_next = PH_REJ;
                    end
                    else
                    begin
                        phase_next = PH_LEN;
                        type_next  = 32'd0;
                        crc_next   = 32'd0;
                    end
                end
            end
            PH_DONE:
            begin
                evt.code = EV_DONE;
            end
            PH_REJ:
            begin
                evt.code = EV_REJ;
            end
            default:
            begin
                phase_next = PH_REJ;
                evt.code   = EV_REJ;
            end
        endcase

        // Drop to reject on a failed check or on input that ends mid-file
        if (!chunk_end && cur_phase != PH_DONE && cur_phase != PH_REJ)
        begin
            if (phase_next == PH_REJ || last_byte)
            begin
                phase_next = PH_REJ;
                evt.code   = EV_REJ;
            end
        end
    end

    // Parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIG;
            cnt_reg   <= 3'd0;
            len_reg   <= 32'd0;
            left_reg  <= 32'd0;
            type_reg  <= 32'd0;
            crc_reg   <= 32'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            type_reg  <= type_next;
            crc_reg   <= crc_next;
        end
    end

endmodule

/* design/pcd_queue.sv */
// Short event queue between the framer and the checker.
`include "png_chunk_deframer_defines.svh"

module pcd_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  pcd_pkg::evt_t in_evt,
    output logic          out_valid,
    input  logic          out_ready,
    output pcd_pkg::evt_t out_evt
);
    import pcd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    evt_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_evt   = mem[rd_ptr_reg];

    // Advance pointers with wrap, track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Write the entry on a transfer in
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_evt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `PCD_ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "queue overfilled")
    `PCD_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count lost a push")
    `PCD_ASSERT_NEXT(a_count_down, pop && !push, count_reg == $past(count_reg) - 1'b1, "queue count lost a pop")

endmodule

/* design/pcd_back.sv */
// Chunk checker: kind, IDAT ordering, run starts and the registered result.
`include "png_chunk_deframer_defines.svh"

module pcd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  pcd_pkg::evt_t q_evt,
    output logic          res_valid,
    input  logic          res_ready,
    output pcd_pkg::res_t res
);
    import pcd_pkg::*;

    logic  rej_reg, rej_next;
    logic  saw_reg, saw_next;
    logic  closed_reg, closed_next;
    kind_t prev_reg, prev_next;
    logic  res_valid_reg;
    res_t  res_reg, res_next;

    logic  rej_cur;
    logic  saw_cur;
    logic  closed_cur;
    kind_t prev_cur;
    kind_t kind;
    logic  pop;

    assign q_ready   = !res_valid_reg || res_ready;
    assign pop       = q_valid && q_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Classify the chunk type
    always_comb
    begin
        priority if (q_evt.type_word == TYPE_IDAT)
            kind = KIND_IDAT;
        else if (q_evt.type_word == TYPE_FDAT)
            kind = KIND_FDAT;
        else if (q_evt.type_word == TYPE_IEND)
            kind = KIND_IEND;
        else
            kind = KIND_OTHER;
    end

    // Resolve status, ordering checks and run tracking for one event
    always_comb
    begin
        rej_cur    = q_evt.restart ? 1'b0 : rej_reg;
        saw_cur    = q_evt.restart ? 1'b0 : saw_reg;
        closed_cur = q_evt.restart ? 1'b0 : closed_reg;
        prev_cur   = q_evt.restart ? KIND_OTHER : prev_reg;

        rej_next    = rej_cur;
        saw_next    = saw_cur;
        closed_next = closed_cur;
        prev_next   = prev_cur;
        res_next    = '0;

        unique case (q_evt.code)
            EV_PARSE:
            begin
                res_next.status = rej_cur ? ST_REJECT : ST_PARSE;
            end
            EV_DONE:
            begin
                res_next.status = rej_cur ? ST_REJECT : ST_ACCEPT;
            end
            EV_REJ:
            begin
                res_next.status = ST_REJECT;
            end
            EV_CHUNK:
            begin
                if (rej_cur)
                begin
                    res_next.status = ST_REJECT;
                end
                else if (kind == KIND_IDAT && closed_cur)
                begin
                    // IDAT after its run was broken
                    res_next.status = ST_REJECT;
                    rej_next        = 1'b1;
                end
                else
                begin
                    if (kind == KIND_IDAT)
                        saw_next = 1'b1;
                    else if (saw_cur)
                        closed_next = 1'b1;
                    prev_next = kind;
                    if (kind == KIND_IEND || !q_evt.last)
                    begin
                        res_next.status = (kind == KIND_IEND) ? ST_ACCEPT : ST_CHUNK;
                        res_next.kind   = kind;
                        res_next.run    = (kind == KIND_IDAT || kind == KIND_FDAT)
                                          && (prev_cur != kind);
                        res_next.len    = q_evt.len;
                        res_next.crc    = q_evt.crc;
                    end
                    else
                    begin
                        // Input ended on a chunk other than IEND
                        res_next.status = ST_REJECT;
                        rej_next        = 1'b1;
                    end
                end
            end
            default:
            begin
                res_next.status = ST_REJECT;
            end
        endcase
    end

    // Checker state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rej_reg       <= 1'b0;
            saw_reg       <= 1'b0;
            closed_reg    <= 1'b0;
            prev_reg      <= KIND_OTHER;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                rej_reg    <= rej_next;
                saw_reg    <= saw_next;
                closed_reg <= closed_next;
                prev_reg   <= prev_next;
            end
            if (pop)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Payload register, loaded on each transfer from the queue
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    `PCD_ASSERT_IMPLY(a_zero_fields, res_valid_reg && (res_reg.status == ST_PARSE || res_reg.status == ST_REJECT), res_reg.kind == KIND_OTHER && !res_reg.run && res_reg.len == '0 && res_reg.crc == '0, "fields not cleared")
    `PCD_ASSERT_NEXT(a_sticky_reject, pop && !q_evt.restart && rej_reg, res_reg.status == ST_REJECT, "reject not held")
    `PCD_ASSERT_IMPLY(a_run_kind, res_valid_reg && res_reg.run, res_reg.kind == KIND_IDAT || res_reg.kind == KIND_FDAT, "run start on wrong kind")

endmodule
